// ===== rtl/nfpa_pkg.sv =====
package nfpa_pkg;

	localparam int ID_W   = 8;
	localparam int SIZE_W = 16;
	localparam int ST_W   = 3;

	localparam logic [ST_W-1:0] ST_DONE     = 3'd0;
	localparam logic [ST_W-1:0] ST_NOFIT    = 3'd1;
	localparam logic [ST_W-1:0] ST_TOOBIG   = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP      = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	localparam logic [ID_W-1:0]   FREE_TAG     = 8'h23;
	localparam logic [SIZE_W-1:0] SEG_RESET    = 16'd4096;
	localparam int                PADDR_W      = 3;
	localparam logic              REG_SEG_SIZE = 1'b0;
	localparam logic              CMD_STORE    = 1'b0;
	localparam logic              CMD_DELETE   = 1'b1;

	typedef struct packed {
		logic [SIZE_W-1:0] start;
		logic [SIZE_W-1:0] size;
		logic              used;
		logic [ID_W-1:0]   owner;
	} entry_t;

endpackage

// ===== rtl/nfpa_ifs.sv =====
interface nfpa_req_if;
	logic                          valid;
	logic                          ready;
	logic                          command;
	logic [nfpa_pkg::ID_W-1:0]     owner_id;
	logic [nfpa_pkg::SIZE_W-1:0]   request_size;

	modport source (output valid, command, owner_id, request_size, input ready);
	modport sink   (input valid, command, owner_id, request_size, output ready);
endinterface

interface nfpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [nfpa_pkg::ST_W-1:0]     status;
	logic [nfpa_pkg::SIZE_W-1:0]   start_offset;

	modport source (output valid, status, start_offset, input ready);
	modport sink   (input valid, status, start_offset, output ready);
endinterface

// ===== rtl/nfpa_ram.sv =====
module nfpa_ram #(
	parameter int WIDTH = 41,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/next_fit_partition_allocator.sv =====
// Next-fit partition allocator. The partition table (start, size, used, owner) sits in a
// one-read one-write RAM with a registered read, so every request walks the table one entry
// a cycle. A transfer on req is a store (command 0) or a delete (command 1); each gives one
// transfer on rsp. Every request first sweeps the table from the top entry down, which
// yields the free-run suffix sums, the next-fit candidate and the owner match. A store that
// goes ahead then re-reads the chosen run, shifts the entries above it and writes the head
// and, if the run is split, the free tail. The walk is bound by the single table read port,
// and a finished result may wait for the result slot to drain. After reset the block writes
// entry 0 in S_INIT before req goes ready. Writing segment_size (APB, byte address 0)
// reinitialises the table to one free partition; only do so while the block is idle.
module next_fit_partition_allocator #(
	parameter int MAX_PARTS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	nfpa_req_if.sink                      req,
	nfpa_rsp_if.source                    rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [nfpa_pkg::PADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);
	import nfpa_pkg::*;

	localparam int AW = $clog2(MAX_PARTS);
	localparam int CW = AW + 1;

	typedef enum logic [9:0] {
		S_INIT = 10'b00_0000_0001,
		S_IDLE = 10'b00_0000_0010,
		S_SCAN = 10'b00_0000_0100,
		S_DEC  = 10'b00_0000_1000,
		S_RUN  = 10'b00_0001_0000,
		S_CHK  = 10'b00_0010_0000,
		S_COPY = 10'b00_0100_0000,
		S_FIX  = 10'b00_1000_0000,
		S_FIX2 = 10'b01_0000_0000,
		S_RESP = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic [SIZE_W-1:0] seg_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     fp_q;

	// latched request
	logic              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [SIZE_W-1:0] req_q;

	// table walk: read issue and returning data tag
	logic [AW-1:0]     rd_q;
	logic              more_q;
	logic [AW-1:0]     end_q;
	logic              vld_s1;
	logic [AW-1:0]     idx_s1;

	// sweep results
	logic [SIZE_W:0]   suf_q;
	logic              hi_found_q, lo_found_q, dup_q;
	logic [AW-1:0]     hi_q, lo_q, where_q;
	entry_t            where_ent_q;

	// chosen run
	logic [AW-1:0]     x_q;
	logic [SIZE_W-1:0] xstart_q;
	logic [SIZE_W:0]   sum_q;
	logic [CW-1:0]     k_q;
	logic              split_q;
	logic              up_q;
	logic [CW-1:0]     shift_q;
	logic [CW-1:0]     newcnt_q;

	logic [ST_W-1:0]   res_status_q;
	logic [SIZE_W-1:0] res_off_q;
	logic              out_valid_q;
	logic [ST_W-1:0]   out_status_q;
	logic [SIZE_W-1:0] out_off_q;

	logic              cfg_wr;
	logic              req_acc;
	logic              slot_free;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	entry_t            ram_rdata;
	logic [SIZE_W:0]   suf_new;
	logic              fits;
	logic [SIZE_W:0]   sum_new;
	logic              chk_split;
	logic [CW-1:0]     chk_lo;

	assign cfg_wr    = psel && penable && pwrite && (paddr[2] == REG_SEG_SIZE);
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_SEG_SIZE) ? {16'd0, seg_q} : 32'd0;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.start_offset = out_off_q;

	// sweep step: suffix sum of the free run from this entry up
	assign suf_new   = ram_rdata.used ? '0 : suf_q + {1'b0, ram_rdata.size};
	assign fits      = !ram_rdata.used && (suf_new >= {1'b0, req_q});
	assign sum_new   = sum_q + {1'b0, ram_rdata.size};
	assign chk_split = ({1'b0, req_q} < sum_q);
	assign chk_lo    = (k_q == CW'(1) && chk_split) ? CW'(x_q) + CW'(1) : CW'(x_q) + k_q;

	nfpa_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (MAX_PARTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_q),
		.rdata (ram_rdata)
	);

	// table write port
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		if (cfg_wr || state_q == S_INIT) begin
			ram_we          = 1'b1;
			ram_wdata.size  = cfg_wr ? pwdata[15:0] : seg_q;
			ram_wdata.owner = FREE_TAG;
		end else begin
			unique case (state_q)
				S_DEC: begin
					if (cmd_q == CMD_DELETE && dup_q) begin
						ram_we          = 1'b1;
						ram_waddr       = where_q;
						ram_wdata       = where_ent_q;
						ram_wdata.used  = 1'b0;
						ram_wdata.owner = FREE_TAG;
					end
				end
				S_COPY: begin
					ram_we    = vld_s1;
					ram_waddr = up_q ? idx_s1 + AW'(1) : AW'({1'b0, idx_s1} - shift_q);
					ram_wdata = ram_rdata;
				end
				S_FIX: begin
					ram_we          = 1'b1;
					ram_waddr       = x_q;
					ram_wdata.start = xstart_q;
					ram_wdata.size  = split_q ? req_q : sum_q[SIZE_W-1:0];
					ram_wdata.used  = 1'b1;
					ram_wdata.owner = id_q;
				end
				S_FIX2: begin
					ram_we          = 1'b1;
					ram_waddr       = x_q + AW'(1);
					ram_wdata.start = xstart_q + req_q;
					ram_wdata.size  = sum_q[SIZE_W-1:0] - req_q;
					ram_wdata.used  = 1'b0;
					ram_wdata.owner = FREE_TAG;
				end
				default: begin
				end
			endcase
		end
	end

	// result slot: a finished result may wait here while the next request runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_RESP && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && slot_free) begin
			out_status_q <= res_status_q;
			out_off_q    <= res_off_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			seg_q   <= SEG_RESET;
			count_q <= CW'(1);
			fp_q    <= '0;
			more_q  <= 1'b0;
			vld_s1  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				seg_q   <= pwdata[15:0];
				count_q <= CW'(1);
				fp_q    <= '0;
			end
			unique case (state_q)
				S_INIT: begin
					state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (req_acc) begin
						more_q  <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= more_q;
					if (more_q && rd_q == '0) begin
						more_q <= 1'b0;
					end
					if (vld_s1 && idx_s1 == '0) begin
						vld_s1  <= 1'b0;
						more_q  <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					state_q <= S_RESP;
					if (cmd_q == CMD_STORE && req_q <= seg_q && req_q != '0
							&& (hi_found_q || lo_found_q)) begin
						fp_q <= hi_found_q ? hi_q : lo_q;
						if (!dup_q) begin
							more_q  <= 1'b1;
							state_q <= S_RUN;
						end
					end
				end
				S_RUN: begin
					vld_s1 <= 1'b1;
					if (vld_s1 && sum_new >= {1'b0, req_q}) begin
						vld_s1  <= 1'b0;
						more_q  <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (k_q == CW'(1) && chk_split && count_q == CW'(MAX_PARTS)) begin
						state_q <= S_RESP;
					end else if (chk_lo >= count_q) begin
						state_q <= S_FIX;
					end else begin
						more_q  <= 1'b1;
						state_q <= S_COPY;
					end
				end
				S_COPY: begin
					vld_s1 <= more_q;
					if (more_q && rd_q == end_q) begin
						more_q <= 1'b0;
					end
					if (vld_s1 && idx_s1 == end_q) begin
						vld_s1  <= 1'b0;
						more_q  <= 1'b0;
						state_q <= S_FIX;
					end
				end
				S_FIX: begin
					count_q <= newcnt_q;
					state_q <= split_q ? S_FIX2 : S_RESP;
				end
				S_FIX2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_INIT;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		idx_s1 <= rd_q;
		unique case (state_q)
			S_IDLE: begin
				cmd_q      <= req.command;
				id_q       <= req.owner_id;
				req_q      <= req.request_size;
				rd_q       <= AW'(count_q - CW'(1));
				suf_q      <= '0;
				hi_found_q <= 1'b0;
				lo_found_q <= 1'b0;
				dup_q      <= 1'b0;
			end
			S_SCAN: begin
				if (more_q && rd_q != '0) begin
					rd_q <= rd_q - AW'(1);
				end
				if (vld_s1) begin
					suf_q <= suf_new;
					if (fits && idx_s1 >= fp_q) begin
						hi_found_q <= 1'b1;
						hi_q       <= idx_s1;
					end
					if (fits && idx_s1 < fp_q) begin
						lo_found_q <= 1'b1;
						lo_q       <= idx_s1;
					end
					if (ram_rdata.used && ram_rdata.owner == id_q) begin
						dup_q       <= 1'b1;
						where_q     <= idx_s1;
						where_ent_q <= ram_rdata;
					end
				end
			end
			S_DEC: begin
				res_off_q <= '0;
				x_q       <= hi_found_q ? hi_q : lo_q;
				rd_q      <= hi_found_q ? hi_q : lo_q;
				sum_q     <= '0;
				k_q       <= '0;
				if (cmd_q == CMD_DELETE) begin
					res_status_q <= dup_q ? ST_DONE : ST_NOTFOUND;
				end else if (req_q > seg_q) begin
					res_status_q <= ST_TOOBIG;
				end else if (req_q == '0 || !(hi_found_q || lo_found_q)) begin
					res_status_q <= ST_NOFIT;
				end else begin
					res_status_q <= ST_DUP;
				end
			end
			S_RUN: begin
				rd_q <= rd_q + AW'(1);
				if (vld_s1) begin
					sum_q <= sum_new;
					k_q   <= k_q + CW'(1);
					if (k_q == '0) begin
						xstart_q <= ram_rdata.start;
					end
				end
			end
			S_CHK: begin
				split_q      <= chk_split;
				up_q         <= (k_q == CW'(1)) && chk_split;
				shift_q      <= k_q - CW'(1) - CW'(chk_split);
				newcnt_q     <= count_q - k_q + CW'(1) + CW'(chk_split);
				res_status_q <= ST_NOFIT;
				if ((k_q == CW'(1)) && chk_split) begin
					rd_q  <= AW'(count_q - CW'(1));
					end_q <= x_q + AW'(1);
				end else begin
					rd_q  <= AW'(chk_lo);
					end_q <= AW'(count_q - CW'(1));
				end
			end
			S_COPY: begin
				if (more_q && rd_q != end_q) begin
					rd_q <= up_q ? rd_q - AW'(1) : rd_q + AW'(1);
				end
			end
			S_FIX: begin
				res_status_q <= ST_DONE;
				res_off_q    <= xstart_q;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/nfpa_checker.sv =====
module nfpa_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [nfpa_pkg::ST_W-1:0]     rsp_status,
	input logic [nfpa_pkg::SIZE_W-1:0]   rsp_start_offset
);
	import nfpa_pkg::*;

	// the request side takes one request at a time: ready drops right after a transfer
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("req accepted twice back to back");

	// offset only carries meaning on a completed store
	a_offset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_DONE |-> rsp_start_offset == '0)
		else $error("nonzero offset on failed request");

	// a new result always follows a busy cycle on the request side
	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(!req_ready))
		else $error("result raised while idle");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_start_offset))
		else $error("stalled result changed");
endmodule

bind next_fit_partition_allocator nfpa_checker u_nfpa_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_start_offset (rsp.start_offset)
);

// ===== sim/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import nfpa_pkg::*;

	localparam int MAX_PARTS = 32;
	localparam int CYCLE_LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	nfpa_req_if req ();
	nfpa_rsp_if rsp ();

	next_fit_partition_allocator #(.MAX_PARTS(MAX_PARTS)) u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #5 clk = ~clk;

	// shadow of the partition table, kept in step with accepted transfers
	logic [SIZE_W-1:0] seg_bytes;
	logic [SIZE_W-1:0] tbl_start [MAX_PARTS];
	logic [SIZE_W-1:0] tbl_size [MAX_PARTS];
	logic              tbl_used [MAX_PARTS];
	logic [ID_W-1:0]   tbl_owner [MAX_PARTS];
	int                n_entries;
	int                next_fit;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [SIZE_W-1:0] start_offset;
	} answer_t;

	answer_t pending_answers [$];
	int errors = 0;
	int cycles = 0;
	bit rsp_hold = 1'b0;	// long receiver stall when set

	function automatic void clear_table();
		tbl_start[0] = '0;
		tbl_size[0] = seg_bytes;
		tbl_used[0] = 1'b0;
		tbl_owner[0] = FREE_TAG;
		n_entries = 1;
		next_fit = 0;
	endfunction

	// length of the free run from idx that covers want, 0 if none
	function automatic int free_run(int idx, int want);
		int acc;
		acc = 0;
		for (int j = idx; j < n_entries; j++) begin
			if (tbl_used[j])
				return 0;
			acc += tbl_size[j];
			if (acc >= want)
				return j - idx + 1;
		end
		return 0;
	endfunction

	function automatic int find_owner(logic [ID_W-1:0] id);
		for (int i = 0; i < n_entries; i++)
			if (tbl_used[i] && tbl_owner[i] == id)
				return i;
		return -1;
	endfunction

	function automatic answer_t allocate(logic [ID_W-1:0] id, int want);
		answer_t a;
		int x, k, total;
		bit hit;
		a = '0;
		hit = 0;
		x = 0;
		k = 0;
		if (want > seg_bytes) begin
			a.status = ST_TOOBIG;
			return a;
		end
		if (want == 0) begin
			a.status = ST_NOFIT;
			return a;
		end
		for (int i = next_fit; i < n_entries && !hit; i++) begin
			k = free_run(i, want);
			if (k != 0) begin x = i; hit = 1; end
		end
		for (int i = 0; i < next_fit && !hit; i++) begin
			k = free_run(i, want);
			if (k != 0) begin x = i; hit = 1; end
		end
		if (!hit) begin
			a.status = ST_NOFIT;
			return a;
		end
		next_fit = x;
		if (find_owner(id) >= 0) begin
			a.status = ST_DUP;
			return a;
		end
		total = 0;
		for (int i = 0; i < k; i++)
			total += tbl_size[x + i];
		if (k == 1 && want < total && n_entries >= MAX_PARTS) begin
			a.status = ST_NOFIT;
			return a;
		end
		// fold the run into entry x
		if (k > 1) begin
			for (int i = x + 1; i + k - 1 < n_entries; i++) begin
				tbl_start[i] = tbl_start[i + k - 1];
				tbl_size[i] = tbl_size[i + k - 1];
				tbl_used[i] = tbl_used[i + k - 1];
				tbl_owner[i] = tbl_owner[i + k - 1];
			end
			n_entries -= k - 1;
		end
		tbl_size[x] = total;
		if (want < total) begin
			for (int i = n_entries; i > x + 1; i--) begin
				tbl_start[i] = tbl_start[i - 1];
				tbl_size[i] = tbl_size[i - 1];
				tbl_used[i] = tbl_used[i - 1];
				tbl_owner[i] = tbl_owner[i - 1];
			end
			tbl_start[x + 1] = tbl_start[x] + want;
			tbl_size[x + 1] = total - want;
			tbl_used[x + 1] = 1'b0;
			tbl_owner[x + 1] = FREE_TAG;
			n_entries++;
			tbl_size[x] = want;
		end
		tbl_used[x] = 1'b1;
		tbl_owner[x] = id;
		a.status = ST_DONE;
		a.start_offset = tbl_start[x];
		return a;
	endfunction

	function automatic answer_t release_owner(logic [ID_W-1:0] id);
		answer_t a;
		int w;
		a = '0;
		w = find_owner(id);
		if (w < 0) begin
			a.status = ST_NOTFOUND;
		end else begin
			tbl_used[w] = 1'b0;
			tbl_owner[w] = FREE_TAG;
			a.status = ST_DONE;
		end
		return a;
	endfunction

	// one transfer on req; prediction happens at acceptance
	task automatic send_request(logic cmd, logic [ID_W-1:0] id, logic [SIZE_W-1:0] want);
		int gap;
		gap = $urandom_range(0, 8);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		repeat (gap) @(negedge clk);
		req.valid <= 1'b1;
		req.command <= cmd;
		req.owner_id <= id;
		req.request_size <= want;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (cmd == CMD_STORE)
			pending_answers.push_back(allocate(id, want));
		else
			pending_answers.push_back(release_owner(id));
		@(negedge clk);
		req.valid = 1'b0;
	endtask

	task automatic wait_idle();
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (3 * MAX_PARTS + 20) @(negedge clk);
	endtask

	task automatic write_segment(logic [SIZE_W-1:0] bytes);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= PADDR_W'(REG_SEG_SIZE) << 2;
		pwdata <= {16'd0, bytes};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		seg_bytes = bytes;
		clear_table();
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// response side: random back-pressure, sample at rising edge
	initial begin
		int stall;
		answer_t exp_a;
		rsp.ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = $urandom_range(0, 8);
			if ($urandom_range(0, 3) == 0)
				stall = 0;
			repeat (stall) @(negedge clk);
			while (rsp_hold)
				@(negedge clk);
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!rsp.valid)
				@(posedge clk);
			if (pending_answers.size() == 0) begin
				$error("unexpected transfer: status %0d start_offset %0d",
					rsp.status, rsp.start_offset);
				errors++;
			end else begin
				exp_a = pending_answers.pop_front();
				if (rsp.status !== exp_a.status) begin
					$error("status: expected %0d actual %0d", exp_a.status, rsp.status);
					errors++;
				end
				if (rsp.start_offset !== exp_a.start_offset) begin
					$error("start_offset: expected %0d actual %0d",
						exp_a.start_offset, rsp.start_offset);
					errors++;
				end
			end
			@(negedge clk);
			rsp.ready <= 1'b0;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// zero request, too big, exact fit, duplicate, delete misses, table full
	task automatic test_directed();
		write_segment(16'd100);
		send_request(CMD_STORE, 8'd1, 16'd0);
		send_request(CMD_STORE, 8'd1, 16'd101);
		send_request(CMD_STORE, 8'd1, 16'd30);
		send_request(CMD_STORE, 8'd1, 16'd10);
		send_request(CMD_STORE, 8'd2, 16'd30);
		send_request(CMD_DELETE, 8'd1, 16'd0);
		send_request(CMD_DELETE, 8'd1, 16'd0);
		send_request(CMD_DELETE, FREE_TAG, 16'hFFFF);
		send_request(CMD_STORE, 8'hFF, 16'd70);	// no free run covers it, before or after the wrap
		send_request(CMD_STORE, 8'h00, 16'd1);
		wait_idle();
		// fill the table with single-byte partitions
		write_segment(16'd40);
		for (int i = 0; i < MAX_PARTS + 2; i++)
			send_request(CMD_STORE, 8'(i + 8'h40), 16'd1);
		wait_idle();
		// empty segment; full-width segment
		write_segment(16'd0);
		send_request(CMD_STORE, 8'd5, 16'd1);
		send_request(CMD_DELETE, 8'd5, 16'd1);
		wait_idle();
		write_segment(16'hFFFF);
		send_request(CMD_STORE, 8'hAA, 16'hFFFF);
		send_request(CMD_STORE, 8'h55, 16'h8000);
		wait_idle();
	endtask

	// mostly stores with a small id pool so duplicates and deletes land
	task automatic test_random(int count, logic [SIZE_W-1:0] bytes);
		logic [SIZE_W-1:0] want;
		write_segment(bytes);
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 9))
				0: want = 16'($urandom());
				1: want = 16'd0;
				default: want = 16'($urandom_range(1, (bytes >> 3) + 1));
			endcase
			send_request($urandom_range(0, 2) == 0 ? CMD_DELETE : CMD_STORE,
				$urandom_range(0, 5) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 40)),
				want);
		end
		wait_idle();
	endtask

	// receiver holds off while requests keep coming
	task automatic test_backpressure();
		write_segment(SEG_RESET);
		rsp_hold = 1'b1;
		fork
			begin
				repeat (400) @(negedge clk);
				rsp_hold = 1'b0;
			end
			for (int n = 0; n < 12; n++)
				send_request(CMD_STORE, 8'(n), 16'(n + 1));
		join
		wait_idle();
	endtask

	initial begin
		req.valid = 1'b0;
		req.command = CMD_STORE;
		req.owner_id = '0;
		req.request_size = '0;
		seg_bytes = SEG_RESET;
		clear_table();
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_backpressure();
		test_random(500, SEG_RESET);
		test_random(400, 16'd200);
		test_random(300, 16'hFFFF);
		test_random(300, 16'd1);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
